// ===== src/svpwm_pkg.sv =====
package svpwm_pkg;

    // Field widths of the stream and configuration port.
    localparam int unsigned VOLT_W   = 16;
    localparam int unsigned SECTOR_W = 3;
    localparam int unsigned DUTY_W   = 17;
    localparam int unsigned CMP_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Packed stream widths, padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 104;

    // Internal working widths.
    localparam int unsigned SUM_W  = 33;   // beta*2^14 + alpha*0.866 + rounding
    localparam int unsigned TERM_W = 19;   // intermediate terms and raw duties
    localparam int unsigned P1_W   = 34;   // duty * period
    localparam int unsigned P2_W   = 51;   // duty * period * gain
    localparam int unsigned ACC_W  = 52;   // product plus offset and rounding

    // 0.866 in Q15.
    localparam logic signed [15:0] K0866 = 16'sd28377;

    // Duty saturation limits.
    localparam logic signed [TERM_W-1:0] DUTY_MAX = 19'sd65535;
    localparam logic signed [TERM_W-1:0] DUTY_MIN = -19'sd65536;

    // Register reset values.
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [CFG_W-1:0] GAIN_RST   = 16'd16384;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 1'b0,
        CFG_GAIN   = 1'b1
    } t_cfg_idx;

    // Sector codes.
    localparam logic [SECTOR_W-1:0] SECT_1 = 3'd1;
    localparam logic [SECTOR_W-1:0] SECT_2 = 3'd2;
    localparam logic [SECTOR_W-1:0] SECT_3 = 3'd3;
    localparam logic [SECTOR_W-1:0] SECT_4 = 3'd4;
    localparam logic [SECTOR_W-1:0] SECT_5 = 3'd5;
    localparam logic [SECTOR_W-1:0] SECT_6 = 3'd6;
    localparam logic [SECTOR_W-1:0] SECT_BASE = 3'd3;
    localparam logic [SECTOR_W-1:0] SECT_MIRROR = 3'd7;

endpackage

// ===== src/space_vector_pwm_generator_core.sv =====
// Space vector PWM generator. Each transfer on the input stream carries one
// alpha/beta voltage command in Q1.15; one transfer on the output stream
// returns the sector (1 to 6), the three saturated phase duties in Q2.15 and
// the three timer compare values, each rounded and clamped to 0..pwm_period.
// The datapath is a five-stage pipeline (term sum, sector and duty select,
// duty times period, times gain, offset and clamp), so a new pair is taken
// every cycle while the pipeline is not held. A result passes the stage registers
// in order; the whole pipeline holds while the output register is full and not
// taken. pwm_period and bus_gain must be written through the configuration port
// only while no item is in flight; the block does not enforce this. Every write
// is taken at once.
module space_vector_pwm_generator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svpwm_pkg::CFG_W-1:0]         i_cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: u_alpha [15:0], u_beta [31:16]
    input  logic [svpwm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: sector [2:0], duty_a [19:3], duty_b [36:20], duty_c [53:37],
    //        cmp_a [69:54], cmp_b [85:70], cmp_c [101:86], zero [103:102]
    output logic [svpwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import svpwm_pkg::*;

    localparam int unsigned NSTG = 5;

    // Configuration registers.
    logic [CFG_W-1:0] r_period, r_gain;

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    // Stage 1.
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [VOLT_W-1:0] r_beta;
    // Stage 2.
    logic [SECTOR_W-1:0]        r_sec2;
    logic signed [DUTY_W-1:0]   r_duty2 [3];
    // Stage 3.
    logic [SECTOR_W-1:0]        r_sec3;
    logic signed [DUTY_W-1:0]   r_duty3 [3];
    logic signed [P1_W-1:0]     r_p1 [3];
    // Stage 4.
    logic [SECTOR_W-1:0]        r_sec4;
    logic signed [DUTY_W-1:0]   r_duty4 [3];
    logic signed [P2_W-1:0]     r_p2 [3];
    // Stage 5 (output register).
    logic [SECTOR_W-1:0]        r_sec5;
    logic signed [DUTY_W-1:0]   r_duty5 [3];
    logic [CMP_W-1:0]           r_cmp5 [3];

    // Combinational stage logic.
    logic signed [VOLT_W-1:0]   w_alpha, w_beta;
    logic signed [31:0]         w_ak;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [TERM_W-1:0]   w_t1, w_t2, w_t3;
    logic signed [TERM_W-1:0]   w_raw [3];
    logic [SECTOR_W-1:0]        n_sec;
    logic signed [DUTY_W-1:0]   n_duty [3];
    logic signed [ACC_W-1:0]    w_acc [3];
    logic signed [ACC_W-1:0]    w_shf [3];
    logic [CMP_W-1:0]           n_cmp [3];

    // The pipeline moves whenever the output register is empty or drained.
    assign w_en          = !r_vld[NSTG-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: beta/2 + 0.866*alpha in Q30 with the rounding half added.
    assign w_alpha = $signed(s_axis_tdata[VOLT_W-1:0]);
    assign w_beta  = $signed(s_axis_tdata[2*VOLT_W-1:VOLT_W]);
    assign w_ak    = w_alpha * K0866;
    assign n_sum   = $signed({{(SUM_W-VOLT_W-14){w_beta[VOLT_W-1]}}, w_beta, 14'b0})
                   + SUM_W'(w_ak) + SUM_W'(16384);

    // Stage 2: terms, sector and saturated duties.
    always_comb begin
        logic [SECTOR_W-1:0] s;
        w_t1 = TERM_W'(r_beta);
        w_t2 = TERM_W'($signed(r_sum[SUM_W-1:15]));
        w_t3 = w_t2 - w_t1;
        s = SECT_BASE;
        if (w_t2 > 0) s = s - 3'd1;
        if (w_t3 > 0) s = s - 3'd1;
        if (w_t1 < 0) s = SECT_MIRROR - s;
        n_sec = s;
        if (s == SECT_1 || s == SECT_4) begin
            w_raw[0] = w_t2;
            w_raw[1] = w_t1 - w_t3;
            w_raw[2] = -w_t2;
        end else if (s == SECT_2 || s == SECT_5) begin
            w_raw[0] = w_t3 + w_t2;
            w_raw[1] = w_t1;
            w_raw[2] = -w_t1;
        end else begin
            w_raw[0] = w_t3;
            w_raw[1] = -w_t3;
            w_raw[2] = -(w_t1 + w_t2);
        end
        for (int i = 0; i < 3; i++) begin
            if (w_raw[i] > DUTY_MAX) begin
                n_duty[i] = DUTY_MAX[DUTY_W-1:0];
            end else if (w_raw[i] < DUTY_MIN) begin
                n_duty[i] = DUTY_MIN[DUTY_W-1:0];
            end else begin
                n_duty[i] = w_raw[i][DUTY_W-1:0];
            end
        end
    end

    // Stage 5: add half period and rounding, drop 30 bits, clamp to 0..period.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = ACC_W'(r_p2[i])
                     + $signed({{(ACC_W-CFG_W-29){1'b0}}, r_period, 29'b0})
                     + $signed(ACC_W'(64'd1 << 29));
            w_shf[i] = w_acc[i] >>> 30;
            if (w_shf[i] < 0) begin
                n_cmp[i] = '0;
            end else if (w_shf[i] > $signed({{(ACC_W-CFG_W){1'b0}}, r_period})) begin
                n_cmp[i] = r_period;
            end else begin
                n_cmp[i] = w_shf[i][CMP_W-1:0];
            end
        end
    end

    // Pipeline data registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum  <= n_sum;
            r_beta <= w_beta;
            r_sec2 <= n_sec;
            r_sec3 <= r_sec2;
            r_sec4 <= r_sec3;
            r_sec5 <= r_sec4;
            for (int i = 0; i < 3; i++) begin
                r_duty2[i] <= n_duty[i];
                r_duty3[i] <= r_duty2[i];
                r_p1[i]    <= r_duty2[i] * $signed({1'b0, r_period});
                r_duty4[i] <= r_duty3[i];
                r_p2[i]    <= r_p1[i] * $signed({1'b0, r_gain});
                r_duty5[i] <= r_duty4[i];
                r_cmp5[i]  <= n_cmp[i];
            end
        end
    end

    // Output stream.
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {2'b00, r_cmp5[2], r_cmp5[1], r_cmp5[0],
                            r_duty5[2], r_duty5[1], r_duty5[0], r_sec5};

`ifndef SYNTHESIS
    // A result always carries a real sector.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_sec5 >= SECT_1 && r_sec5 <= SECT_6))
        else $error("sector out of range");

    // Compare values never exceed the period.
    a_cmp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_cmp5[0] <= r_period && r_cmp5[1] <= r_period
                           && r_cmp5[2] <= r_period))
        else $error("compare value above period");

    // An item in the last inner stage reaches the output when the pipe moves.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[NSTG-2]) |=> m_axis_tvalid)
        else $error("item lost before output register");
`endif

endmodule
